// ===== rtl/core/sfd_pkg.sv =====
// Package for the sensor frame deframer: frame constants, parser phase
// encoding, target codes and the frame record passed from parser to decoder.
// No dependencies.
package sfd_pkg;

  // Payload length limit; the frame is dropped when this many bytes arrive
  localparam int unsigned PayloadMax = 30;
  localparam int unsigned IdxW       = $clog2(PayloadMax + 1);
  // Payload bytes kept for decoding (command, spare, ID, four data bytes)
  localparam int unsigned KeptBytes  = 7;
  localparam int unsigned KeptW      = $clog2(KeptBytes);

  localparam logic [7:0] SyncByte  = 8'hFF;
  localparam logic [7:0] DelimByte = 8'h26;
  localparam logic [7:0] CmdSens   = 8'h1C;

  localparam logic [7:0] IdBoom   = 8'hE2;
  localparam logic [7:0] IdBucket = 8'hE4;
  localparam logic [7:0] IdArtic  = 8'hE5;
  localparam logic [7:0] IdAcBk   = 8'hE6;
  localparam logic [7:0] IdRadar  = 8'hD7;

  localparam logic [2:0] TgtBoom   = 3'd0;
  localparam logic [2:0] TgtBucket = 3'd1;
  localparam logic [2:0] TgtArtic  = 3'd2;
  localparam logic [2:0] TgtAcBk   = 3'd3;
  localparam logic [2:0] TgtRadar  = 3'd4;

  typedef enum logic [2:0] {
    PhHunt,
    PhLen,
    PhPay,
    PhDelim,
    PhChk
  } phase_e;

  // A frame that passed checksum and command check, with the bytes for decoding
  typedef struct packed {
    logic       hit;
    logic [7:0] id;
    logic [7:0] b3;
    logic [7:0] b4;
    logic [7:0] b5;
    logic [7:0] b6;
  } frame_t;

endpackage

// ===== rtl/core/sfd_byte_if.sv =====
// Byte channel interface: valid/ready handshake carrying one received byte.
// No dependencies.
interface sfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/sfd_res_if.sv =====
// Result channel interface: valid/ready handshake carrying one decoded update.
// No dependencies.
interface sfd_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  target;
  logic [31:0] float_bits;
  logic [15:0] accel_value;
  logic [15:0] brake_value;
  logic        radar_detected;

  modport source (output valid, output target, output float_bits, output accel_value,
                  output brake_value, output radar_detected, input ready);
  modport sink (input valid, input target, input float_bits, input accel_value,
                input brake_value, input radar_detected, output ready);
endinterface

// ===== rtl/core/sfd_parser.sv =====
// Frame parser: input byte register, framing state machine, running checksum
// and kept payload bytes. Depends on sfd_pkg and sfd_byte_if.
module sfd_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  sfd_byte_if.sink       rx_i,
  input  logic           adv_i,
  output sfd_pkg::frame_t frame_o
);
  import sfd_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       take;

  phase_e                     phase_q, phase_d;
  logic [7:0]                 sum_q, sum_d;
  logic [7:0]                 len_q, len_d;
  logic [IdxW-1:0]            idx_q, idx_d;
  logic [KeptBytes-1:0][7:0]  pb_q, pb_d;

  logic [IdxW-1:0] idx_inc;
  logic [7:0]      need;
  logic            reached;
  logic            abort;

  // Input register: take a new byte while empty or while the held one is consumed
  assign take       = in_valid_q && adv_i;
  assign rx_i.ready = !in_valid_q || adv_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.valid && rx_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (take) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  // Payload length bookkeeping
  assign idx_inc = idx_q + IdxW'(1);
  assign need    = (len_q > 8'd2) ? (len_q - 8'd2) : 8'd1;
  assign reached = 9'(idx_inc) >= {1'b0, need};
  assign abort   = idx_inc >= IdxW'(PayloadMax);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (take) begin
      unique case (phase_q)
        PhHunt:  phase_d = (in_byte_q == SyncByte) ? PhLen : PhHunt;
        PhLen:   phase_d = PhPay;
        PhPay: begin
          if (abort) begin
            phase_d = PhHunt;
          end else if (reached) begin
            phase_d = PhDelim;
          end
        end
        PhDelim: phase_d = (in_byte_q == DelimByte) ? PhChk : PhHunt;
        PhChk:   phase_d = PhHunt;
        default: phase_d = PhHunt;
      endcase
    end
  end

  // Checksum, length, index and payload updates per phase
  always_comb begin
    sum_d = sum_q;
    len_d = len_q;
    idx_d = idx_q;
    pb_d  = pb_q;
    if (take) begin
      unique case (phase_q)
        PhLen: begin
          len_d = in_byte_q;
          sum_d = sum_q + in_byte_q;
          idx_d = '0;
        end
        PhPay: begin
          if (idx_q < IdxW'(KeptBytes)) begin
            pb_d[idx_q[KeptW-1:0]] = in_byte_q;
          end
          sum_d = sum_q + in_byte_q;
          idx_d = idx_inc;
        end
        PhDelim: begin
          if (in_byte_q == DelimByte) begin
            sum_d = sum_q + in_byte_q;
          end
        end
        PhChk: ;
        default: begin
          if (in_byte_q == SyncByte) begin
            sum_d = SyncByte;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      sum_q   <= '0;
      len_q   <= '0;
      idx_q   <= '0;
      pb_q    <= '0;
    end else begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      pb_q    <= pb_d;
    end
  end

  // Frame check on the checksum byte
  assign frame_o.hit = take && (phase_q == PhChk) && (sum_q == in_byte_q) &&
                       (pb_q[0] == CmdSens);
  assign frame_o.id  = pb_q[2];
  assign frame_o.b3  = pb_q[3];
  assign frame_o.b4  = pb_q[4];
  assign frame_o.b5  = pb_q[5];
  assign frame_o.b6  = pb_q[6];

  a_hit_in_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_o.hit |-> phase_q == PhChk)
    else $error("frame hit outside checksum phase");

  a_delim_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && phase_q == PhDelim) |=> (phase_q == PhChk || phase_q == PhHunt))
    else $error("bad exit from delimiter phase");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhPay |-> idx_q < IdxW'(PayloadMax))
    else $error("payload index past limit");

endmodule

// ===== rtl/core/sfd_decode.sv =====
// Update decoder: maps the ID of a checked frame to a target and its fields,
// held in the result register. Depends on sfd_pkg and sfd_res_if.
module sfd_decode (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sfd_pkg::frame_t frame_i,
  output logic            adv_o,
  sfd_res_if.source       res_o
);
  import sfd_pkg::*;

  logic        known;
  logic [2:0]  tgt_d;
  logic [31:0] float_d;
  logic [15:0] accel_d, brake_d;
  logic        radar_d;
  logic        load;

  logic        res_valid_q;
  logic [2:0]  tgt_q;
  logic [31:0] float_q;
  logic [15:0] accel_q, brake_q;
  logic        radar_q;

  // Advance the parser whenever the result register is free or drains
  assign adv_o = !res_valid_q || res_o.ready;
  assign load  = adv_o && frame_i.hit && known;

  // Decode the ID into a target and its fields; unrelated fields stay zero
  always_comb begin
    known   = 1'b1;
    tgt_d   = TgtBoom;
    float_d = '0;
    accel_d = '0;
    brake_d = '0;
    radar_d = 1'b0;
    unique case (frame_i.id)
      IdBoom: begin
        tgt_d   = TgtBoom;
        float_d = {frame_i.b6, frame_i.b5, frame_i.b4, frame_i.b3};
      end
      IdBucket: begin
        tgt_d   = TgtBucket;
        float_d = {frame_i.b6, frame_i.b5, frame_i.b4, frame_i.b3};
      end
      IdArtic: begin
        tgt_d   = TgtArtic;
        float_d = {frame_i.b6, frame_i.b5, frame_i.b4, frame_i.b3};
      end
      IdAcBk: begin
        tgt_d   = TgtAcBk;
        accel_d = {frame_i.b3, frame_i.b4};
        brake_d = {frame_i.b5, frame_i.b6};
      end
      IdRadar: begin
        tgt_d   = TgtRadar;
        radar_d = frame_i.b3 != 8'd0;
      end
      default: known = 1'b0;
    endcase
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (adv_o) begin
      res_valid_q <= frame_i.hit && known;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tgt_q   <= tgt_d;
      float_q <= float_d;
      accel_q <= accel_d;
      brake_q <= brake_d;
      radar_q <= radar_d;
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.target         = tgt_q;
  assign res_o.float_bits     = float_q;
  assign res_o.accel_value    = accel_q;
  assign res_o.brake_value    = brake_q;
  assign res_o.radar_detected = radar_q;

  a_rise_from_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(frame_i.hit))
    else $error("result without a checked frame");

  a_tgt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> tgt_q <= TgtRadar)
    else $error("target code out of range");

  a_radar_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && tgt_q == TgtRadar) |-> (float_q == '0 && accel_q == '0))
    else $error("radar result carries stray fields");

endmodule

// ===== rtl/core/sensor_frame_deframer.sv =====
// Sensor frame deframer top level: byte input register and parser feeding
// the update decoder and result register. Depends on sfd_pkg, sfd_byte_if,
// sfd_res_if, sfd_parser and sfd_decode.
//
//   port   dir  fields                                             transfer
//   rx_i   in   rx_byte[7:0]                                       valid & ready
//   res_o  out  target[2:0] float_bits[31:0] accel_value[15:0]     valid & ready
//               brake_value[15:0] radar_detected
//
// One byte per clock sustained while results are taken; the checksum byte first
// sits in the input register, and its result is then loaded into the result
// register when the parser advances, and is valid from there until it transfers.
// The framing state and checksum update in the cycle a byte leaves the input
// register; a stalled result holds the parser, and rx_i.ready drops only when
// the input register is full and the full result register is not taken.
// Reset clears framing state and the kept payload bytes to zero.
module sensor_frame_deframer (
  input  logic      clk_i,
  input  logic      rst_ni,
  sfd_byte_if.sink  rx_i,
  sfd_res_if.source res_o
);
  import sfd_pkg::*;

  logic   adv;
  frame_t frame;

  sfd_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_i),
    .adv_i   (adv),
    .frame_o (frame)
  );

  sfd_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .frame_i (frame),
    .adv_o   (adv),
    .res_o   (res_o)
  );

endmodule
